// File: hdl/hsh_pkg.sv
`timescale 1ns / 1ps
package hsh_pkg;

    localparam logic [31:0] INIT_C2   = 32'h6c796765;
    localparam logic [31:0] INIT_C3   = 32'h74656462;
    localparam logic [31:0] FINAL_XOR = 32'h000000ff;

    localparam int LEN_W         = 7;
    localparam int ABSORB_ROUNDS = 2;
    localparam int FINAL_ROUNDS  = 4;
    localparam int CMDQ_DEPTH    = 2;

    typedef logic [3:0][31:0] t_lanes;

    typedef struct packed {
        logic        do_absorb;
        logic [31:0] absorb_word;
        logic        do_final;
        logic [31:0] tail_word;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_lanes seed_lanes(input logic [63:0] key);
        t_lanes l;
        l[0] = key[31:0];
        l[1] = key[63:32];
        l[2] = INIT_C2 ^ key[31:0];
        l[3] = INIT_C3 ^ key[63:32];
        return l;
    endfunction

    function automatic t_lanes sip_round(input t_lanes l);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        t_lanes      r;
        v0 = l[0];
        v1 = l[1];
        v2 = l[2];
        v3 = l[3];
        v0 = v0 + v1;
        v1 = rotl(v1, 5);
        v1 = v1 ^ v0;
        v0 = rotl(v0, 16);
        v2 = v2 + v3;
        v3 = rotl(v3, 8);
        v3 = v3 ^ v2;
        v0 = v0 + v3;
        v3 = rotl(v3, 7);
        v3 = v3 ^ v0;
        v2 = v2 + v1;
        v1 = rotl(v1, 13);
        v1 = v1 ^ v2;
        v2 = rotl(v2, 16);
        r[0] = v0;
        r[1] = v1;
        r[2] = v2;
        r[3] = v3;
        return r;
    endfunction

endpackage

// File: hdl/hsh_front.sv
`timescale 1ns / 1ps
module hsh_front
    import hsh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_accept,
    input  logic [7:0] i_byte_value,
    input  logic       i_byte_valid,
    input  logic       i_last,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    logic [7:0]       r_held_byte;
    logic             r_held_valid;
    logic [LEN_W-1:0] r_len;

    logic [7:0]       n_held_byte;
    logic             n_held_valid;
    logic [LEN_W-1:0] n_len;
    logic             pair;

    always_comb begin
        pair         = i_byte_valid && r_held_valid;
        n_len        = r_len + LEN_W'(i_byte_valid);
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        if (i_byte_valid) begin
            if (r_held_valid) begin
                n_held_byte  = 8'h00;
                n_held_valid = 1'b0;
            end else begin
                n_held_byte  = i_byte_value;
                n_held_valid = 1'b1;
            end
        end
        o_cmd.do_absorb   = pair;
        o_cmd.absorb_word = {8'h00, i_byte_value, 8'h00, r_held_byte};
        o_cmd.do_final    = i_last;
        o_cmd.tail_word   = {n_len, 1'b0, 16'h0000, (n_held_valid ? n_held_byte : 8'h00)};
        o_cmd_valid       = i_accept && (pair || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_held_byte  <= 8'h00;
            r_held_valid <= 1'b0;
            r_len        <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_held_byte  <= 8'h00;
                r_held_valid <= 1'b0;
                r_len        <= '0;
            end else begin
                r_held_byte  <= n_held_byte;
                r_held_valid <= n_held_valid;
                r_len        <= n_len;
            end
        end
    end

endmodule

// File: hdl/hsh_cmdq.sv
`timescale 1ns / 1ps
module hsh_cmdq
    import hsh_pkg::*;
#(
    parameter int P_DEPTH = CMDQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_data,
    output logic o_full,
    output logic o_rd_valid,
    output t_cmd o_rd_data,
    input  logic i_rd
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_cmd             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full     = (r_count == CNT_W'(P_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rptr];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/hsh_back.sv
`timescale 1ns / 1ps
module hsh_back
    import hsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_key,
    input  logic        i_reseed,
    input  logic [63:0] i_reseed_key,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value
);

    localparam int STEP_W = $clog2(ABSORB_ROUNDS + FINAL_ROUNDS);

    t_back_state       r_state;
    t_back_state       n_state;
    t_lanes            r_lanes;
    logic [STEP_W-1:0] r_step;
    logic              r_final_phase;
    t_cmd              r_cmd;
    logic              r_out_full;
    logic [31:0]       r_hash;

    logic        start;
    logic [31:0] word;
    t_lanes      round_in;
    t_lanes      round_out;
    t_lanes      after;
    logic        absorb_end;
    logic        chain_final;
    logic        final_end;
    logic        done;

    assign start = i_cmd_valid && (!i_cmd.do_final || !r_out_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (start) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (done) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        word     = r_final_phase ? r_cmd.tail_word : r_cmd.absorb_word;
        round_in = r_lanes;
        if (r_step == '0) begin
            round_in[3] = r_lanes[3] ^ word;
        end
        round_out  = sip_round(round_in);
        absorb_end = (r_step == STEP_W'(ABSORB_ROUNDS - 1));
        after      = round_out;
        if (absorb_end) begin
            after[0] = round_out[0] ^ word;
            if (r_final_phase) begin
                after[2] = round_out[2] ^ FINAL_XOR;
            end
        end
        chain_final = absorb_end && !r_final_phase && r_cmd.do_final;
        final_end   = r_final_phase && (r_step == STEP_W'(ABSORB_ROUNDS + FINAL_ROUNDS - 1));
        done        = (absorb_end && !r_final_phase && !r_cmd.do_final) || final_end;
        o_cmd_take  = (r_state == BK_IDLE) && start;
    end

    assign empty        = !r_out_full;
    assign o_hash_value = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_lanes       <= seed_lanes(64'h0);
            r_step        <= '0;
            r_final_phase <= 1'b0;
            r_out_full    <= 1'b0;
        end else if (i_reseed) begin
            r_state <= BK_IDLE;
            r_lanes <= seed_lanes(i_reseed_key);
            r_step  <= '0;
            if (pop && r_out_full) begin
                r_out_full <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (pop && r_out_full) begin
                r_out_full <= 1'b0;
            end
            if (o_cmd_take) begin
                r_final_phase <= !i_cmd.do_absorb;
                r_step        <= '0;
            end else if (r_state == BK_RUN) begin
                r_lanes <= after;
                r_step  <= r_step + 1'b1;
                if (chain_final) begin
                    r_final_phase <= 1'b1;
                    r_step        <= '0;
                end
                if (final_end) begin
                    r_lanes    <= seed_lanes(i_key);
                    r_out_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if ((r_state == BK_RUN) && final_end) begin
            r_hash <= round_out[1] ^ round_out[3];
        end
    end

endmodule

// File: hdl/halfsiphash_byte_stream_hash.sv
`timescale 1ns / 1ps
// Keyed 32-bit byte-stream hash with two compression rounds and four finalization rounds.
// The input side behaves like a queue: an item carries one byte, a byte-valid flag and a
// last flag, and it is taken on a clock edge where push is high and full is low.
// The result side also behaves like a queue: while empty is low, the hash of the most
// recently completed message is on o_hash_value, and pop takes it.
// Only an item with last set produces a result.
// The key is written through i_cfg_we and i_cfg_data. A write reseeds the lanes and drops
// any partial message. Write it only while the block is idle.
// The front part pairs the bytes and builds the tail word. A command queue of
// P_CMDQ_DEPTH entries feeds the back part, which performs one round per cycle.
// For a byte pair, the round unit loads the command and then performs two rounds.
// A final item loads the command, folds in the tail word with two rounds and runs the four
// finalization rounds; if it also completes a byte pair, the pair's two rounds come first.
// While the result is not popped, the round unit keeps absorbing byte pairs. It waits only
// at the next final item, and full rises once the command queue fills.
// Reset seeds the lanes from the all-zero key and empties both queues.
module halfsiphash_byte_stream_hash
    import hsh_pkg::*;
#(
    parameter int P_CMDQ_DEPTH = CMDQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_value,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_key;
    logic        accept;
    logic        front_valid;
    t_cmd        front_cmd;
    logic        q_valid;
    t_cmd        q_cmd;
    logic        q_take;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 64'h0;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_data;
        end
    end

    hsh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (i_cfg_we),
        .i_accept     (accept),
        .i_byte_value (i_byte_value),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_cmd_valid  (front_valid),
        .o_cmd        (front_cmd)
    );

    hsh_cmdq #(
        .P_DEPTH (P_CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_valid),
        .i_wr_data  (front_cmd),
        .o_full     (full),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_cmd),
        .i_rd       (q_take)
    );

    hsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (r_key),
        .i_reseed     (i_cfg_we),
        .i_reseed_key (i_cfg_data),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_take   (q_take),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value)
    );

endmodule

// File: hdl/hsh_checker.sv
`timescale 1ns / 1ps
module hsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_hash_value
);

    // A waiting result must stay in place until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_hash_value)))
        else $error("result changed before it was popped");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) |-> ($past(pop) || !$past(i_rst_n)))
        else $error("result disappeared without a pop");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(i_rst_n))
        else $error("result appeared straight out of reset");

endmodule

bind halfsiphash_byte_stream_hash hsh_checker u_chk (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 180;
    localparam int RANDOM_PHASES  = 6;

    typedef struct {
        logic [7:0] value;
        logic       valid;
        logic       last;
    } byte_item_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_byte_valid = 1'b0;
    logic        i_last       = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [31:0] o_hash_value;
    logic        i_cfg_we     = 1'b0;
    logic [63:0] i_cfg_data   = 64'h0;

    byte_item_t  pending_items[$];
    logic [31:0] expected_hashes[$];

    logic [63:0] key_reg;
    logic [31:0] hash_lanes[4];
    logic [6:0]  msg_len;
    logic [7:0]  odd_byte;
    logic        odd_pending;

    int send_idle_pct = 17;
    int recv_idle_pct = 48;
    int fail_count    = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    halfsiphash_byte_stream_hash dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_byte_value (i_byte_value),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic mix_rounds(input int count);
        for (int r = 0; r < count; r++) begin
            hash_lanes[0] = hash_lanes[0] + hash_lanes[1];
            hash_lanes[1] = rot_left(hash_lanes[1], 5) ^ hash_lanes[0];
            hash_lanes[0] = rot_left(hash_lanes[0], 16);
            hash_lanes[2] = hash_lanes[2] + hash_lanes[3];
            hash_lanes[3] = rot_left(hash_lanes[3], 8) ^ hash_lanes[2];
            hash_lanes[0] = hash_lanes[0] + hash_lanes[3];
            hash_lanes[3] = rot_left(hash_lanes[3], 7) ^ hash_lanes[0];
            hash_lanes[2] = hash_lanes[2] + hash_lanes[1];
            hash_lanes[1] = rot_left(hash_lanes[1], 13) ^ hash_lanes[2];
            hash_lanes[2] = rot_left(hash_lanes[2], 16);
        end
    endtask

    task automatic fold_word(input logic [31:0] word);
        hash_lanes[3] = hash_lanes[3] ^ word;
        mix_rounds(2);
        hash_lanes[0] = hash_lanes[0] ^ word;
    endtask

    task automatic reseed_lanes();
        hash_lanes[0] = key_reg[31:0];
        hash_lanes[1] = key_reg[63:32];
        hash_lanes[2] = hsh_pkg::INIT_C2 ^ key_reg[31:0];
        hash_lanes[3] = hsh_pkg::INIT_C3 ^ key_reg[63:32];
        msg_len     = '0;
        odd_byte    = '0;
        odd_pending = 1'b0;
    endtask

    task automatic hash_byte_item(input logic [7:0] value, input logic valid, input logic last);
        logic [31:0] tail;
        if (valid) begin
            if (odd_pending) begin
                fold_word({8'h00, value, 8'h00, odd_byte});
                odd_pending = 1'b0;
                odd_byte    = '0;
            end else begin
                odd_byte    = value;
                odd_pending = 1'b1;
            end
            msg_len = msg_len + 7'd1;
        end
        if (last) begin
            tail = {msg_len, 1'b0, 16'h0000, (odd_pending ? odd_byte : 8'h00)};
            fold_word(tail);
            hash_lanes[2] = hash_lanes[2] ^ hsh_pkg::FINAL_XOR;
            mix_rounds(4);
            expected_hashes.push_back(hash_lanes[1] ^ hash_lanes[3]);
            reseed_lanes();
        end
    endtask

    task automatic add_item(input logic [7:0] value, input logic valid, input logic last);
        byte_item_t it;
        it.value = value;
        it.valid = valid;
        it.last  = last;
        pending_items.push_back(it);
    endtask

    task automatic add_random_message(ref int counted);
        int  len;
        bit  invalid_end;
        if ($urandom_range(99) < 4) begin
            len = $urandom_range(200, 120);
        end else begin
            len = $urandom_range(12, 0);
        end
        invalid_end = (len == 0) || ($urandom_range(99) < 30);
        for (int b = 0; b < len; b++) begin
            if ($urandom_range(99) < 8) begin
                add_item(8'($urandom), 1'b0, 1'b0);
                counted++;
            end
            add_item(8'($urandom), 1'b1, !invalid_end && (b == len - 1));
            counted++;
        end
        if (invalid_end) begin
            add_item(8'($urandom), 1'b0, 1'b1);
            counted++;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || push || expected_hashes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_key(input logic [63:0] k);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        key_reg = k;
        reseed_lanes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                hash_byte_item(i_byte_value, i_byte_valid, i_last);
            end
            if (!push || !full) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    push         <= 1'b1;
                    i_byte_value <= pending_items[0].value;
                    i_byte_valid <= pending_items[0].valid;
                    i_last       <= pending_items[0].last;
                    pending_items.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected hash, expected none, got %08h",
                             $time, o_hash_value);
                    fail_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (o_hash_value !== want) begin
                        $display("%0t: hash_value mismatch, expected %08h, got %08h",
                                 $time, want, o_hash_value);
                        fail_count++;
                    end
                end
                results_seen++;
                if (results_seen == 30 || results_seen == 300) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("halfsiphash_byte_stream_hash verification failed");
        $finish;
    end

    initial begin
        int          counted;
        logic [63:0] phase_key;
        key_reg = '0;
        reseed_lanes();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed messages with the reset key.
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'h12, 1'b1, 1'b0);
        add_item(8'h34, 1'b1, 1'b0);
        add_item(8'hff, 1'b0, 1'b1);
        add_item(8'h55, 1'b1, 1'b0);
        add_item(8'haa, 1'b0, 1'b0);
        add_item(8'h66, 1'b1, 1'b1);
        // This partial message is dropped by the key write.
        add_item(8'h7f, 1'b1, 1'b0);
        wait_drained();

        write_key(64'hffff_ffff_ffff_ffff);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'h80, 1'b0, 1'b1);
        add_item(8'h01, 1'b1, 1'b0);
        add_item(8'hfe, 1'b1, 1'b0);
        add_item(8'h5a, 1'b1, 1'b1);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 48;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                1:       phase_key = '0;
                3:       phase_key = 64'hffff_ffff_ffff_ffff;
                default: phase_key = {32'($urandom), 32'($urandom)};
            endcase
            write_key(phase_key);
            counted = 0;
            while (counted < PHASE_ITEMS) add_random_message(counted);
            if ($urandom_range(1) == 1) begin
                for (int b = $urandom_range(5, 1); b > 0; b--) begin
                    add_item(8'($urandom), 1'b1, 1'b0);
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("halfsiphash_byte_stream_hash verification clean");
        end else begin
            $display("halfsiphash_byte_stream_hash verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/hsh_pkg.sv
hdl/hsh_front.sv
hdl/hsh_cmdq.sv
hdl/hsh_back.sv
hdl/halfsiphash_byte_stream_hash.sv
hdl/hsh_checker.sv
bench/testbench.sv
